[hw/rtl/binary_angle_atan2_macros.svh]
// assertion macros used by the checker file of the binary angle block
`ifndef BINARY_ANGLE_ATAN2_MACROS_SVH
`define BINARY_ANGLE_ATAN2_MACROS_SVH

// implication checked at every rising edge outside reset
`define BAA_ASSERT(label, clock, rstn, prop) \
	label: assert property (@(posedge clock) disable iff (!rstn) prop) \
		else $error("binary angle check failed");

// same check, also active while reset is asserted
`define BAA_ASSERT_ALWAYS(label, clock, prop) \
	label: assert property (@(posedge clock) prop) \
		else $error("binary angle check failed");

`endif

[hw/rtl/baatan2_pkg.sv]
// shared types, constants and the tangent table of the binary angle block
package baatan2_pkg;

	localparam int MAG_W         = 24;
	localparam int SCALE_W       = 7;
	localparam int PROD_W        = MAG_W + SCALE_W;
	localparam int DVD_W         = 30;
	localparam int DIV_STEPS     = DVD_W;
	localparam int CNT_W         = $clog2(DIV_STEPS);
	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int BIT_W         = $clog2(IDX_W);
	localparam int TAB_W         = 13;
	localparam int ANGLE_W       = 8;

	localparam logic [SCALE_W-1:0] RATIO_SCALE = 7'd127;

	localparam logic [ANGLE_W-1:0] ANGLE_POS_COS = 8'd0;
	localparam logic [ANGLE_W-1:0] ANGLE_POS_SIN = 8'd63;
	localparam logic [ANGLE_W-1:0] ANGLE_NEG_COS = 8'd127;
	localparam logic [ANGLE_W-1:0] ANGLE_NEG_SIN = 8'd191;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_SEARCH,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic start;
		logic div_step;
		logic srch_step;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic special;
		logic div_last;
		logic srch_last;
	} dp_stat_t;

	// tangent thresholds, one per angle step of the first quadrant
	function automatic logic [TAB_W-1:0] tan_step(input logic [IDX_W-1:0] idx);
		logic [TAB_W-1:0] v;
		unique case (idx)
			6'd0:  v = 13'd0;    6'd1:  v = 13'd3;    6'd2:  v = 13'd6;    6'd3:  v = 13'd9;
			6'd4:  v = 13'd12;   6'd5:  v = 13'd15;   6'd6:  v = 13'd18;   6'd7:  v = 13'd22;
			6'd8:  v = 13'd25;   6'd9:  v = 13'd28;   6'd10: v = 13'd31;   6'd11: v = 13'd35;
			6'd12: v = 13'd38;   6'd13: v = 13'd41;   6'd14: v = 13'd45;   6'd15: v = 13'd48;
			6'd16: v = 13'd52;   6'd17: v = 13'd56;   6'd18: v = 13'd60;   6'd19: v = 13'd63;
			6'd20: v = 13'd67;   6'd21: v = 13'd71;   6'd22: v = 13'd76;   6'd23: v = 13'd80;
			6'd24: v = 13'd84;   6'd25: v = 13'd89;   6'd26: v = 13'd94;   6'd27: v = 13'd99;
			6'd28: v = 13'd104;  6'd29: v = 13'd109;  6'd30: v = 13'd115;  6'd31: v = 13'd120;
			6'd32: v = 13'd126;  6'd33: v = 13'd133;  6'd34: v = 13'd140;  6'd35: v = 13'd147;
			6'd36: v = 13'd154;  6'd37: v = 13'd162;  6'd38: v = 13'd171;  6'd39: v = 13'd180;
			6'd40: v = 13'd190;  6'd41: v = 13'd200;  6'd42: v = 13'd211;  6'd43: v = 13'd224;
			6'd44: v = 13'd237;  6'd45: v = 13'd252;  6'd46: v = 13'd268;  6'd47: v = 13'd286;
			6'd48: v = 13'd306;  6'd49: v = 13'd329;  6'd50: v = 13'd354;  6'd51: v = 13'd384;
			6'd52: v = 13'd418;  6'd53: v = 13'd458;  6'd54: v = 13'd507;  6'd55: v = 13'd565;
			6'd56: v = 13'd638;  6'd57: v = 13'd731;  6'd58: v = 13'd856;  6'd59: v = 13'd1029;
			6'd60: v = 13'd1289; 6'd61: v = 13'd1721; 6'd62: v = 13'd2585; 6'd63: v = 13'd5173;
			default: v = 13'd0;
		endcase
		return v;
	endfunction

endpackage

[hw/rtl/baatan2_dp.sv]
// datapath: sign split, scaled restoring divider, table search and output register
module baatan2_dp
	import baatan2_pkg::*;
(
	input  logic                      clk,
	input  logic signed [MAG_W-1:0]   sine_part,
	input  logic signed [MAG_W-1:0]   cosine_part,
	input  dp_cmd_t                   cmd,
	output dp_stat_t                  stat,
	output logic        [ANGLE_W-1:0] angle
);

	logic               sneg, cneg;
	logic [MAG_W-1:0]   s_raw, c_raw, smag, cmag, num, den;
	logic [1:0]         quad;
	logic [PROD_W-1:0]  scaled;
	logic               s_zero, c_zero;
	logic [ANGLE_W-1:0] spec_angle;

	logic [1:0]         quad_q;
	logic               special_q;
	logic [ANGLE_W-1:0] spec_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [MAG_W-1:0]   rem_q;
	logic [MAG_W-1:0]   den_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   idx_q;
	logic [BIT_W-1:0]   bit_q;
	logic [ANGLE_W-1:0] angle_q;

	logic [MAG_W:0]     shifted, trial;
	logic               q_bit;
	logic [MAG_W-1:0]   rem_next;
	logic [IDX_W-1:0]   try_idx;
	logic               try_ok;

	// sign split, quadrant and operand selection
	always_comb begin
		s_raw  = sine_part;
		c_raw  = cosine_part;
		sneg   = s_raw[MAG_W-1];
		cneg   = c_raw[MAG_W-1];
		smag   = sneg ? (~s_raw + 1'b1) : s_raw;
		cmag   = cneg ? (~c_raw + 1'b1) : c_raw;
		s_zero = (s_raw == '0);
		c_zero = (c_raw == '0);
		quad   = {sneg, sneg ^ cneg};
		num    = quad[0] ? cmag : smag;
		den    = quad[0] ? smag : cmag;
		scaled = PROD_W'(num) * PROD_W'(RATIO_SCALE);
	end

	// fixed angles on the axes
	always_comb begin
		if (c_zero) begin
			if (s_zero) begin
				spec_angle = ANGLE_POS_COS;
			end else begin
				spec_angle = sneg ? ANGLE_NEG_SIN : ANGLE_POS_SIN;
			end
		end else begin
			spec_angle = cneg ? ANGLE_NEG_COS : ANGLE_POS_COS;
		end
	end

	// one restoring divide step
	always_comb begin
		shifted  = {rem_q, dvd_q[DVD_W-1]};
		trial    = shifted - {1'b0, den_q};
		q_bit    = !trial[MAG_W];
		rem_next = q_bit ? trial[MAG_W-1:0] : shifted[MAG_W-1:0];
	end

	// one binary search step over the monotonic table
	always_comb begin
		try_idx = idx_q | (IDX_W'(1) << bit_q);
		try_ok  = ({{(DVD_W-TAB_W){1'b0}}, tan_step(try_idx)} <= dvd_q);
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			quad_q    <= quad;
			special_q <= s_zero || c_zero;
			spec_q    <= spec_angle;
			dvd_q     <= scaled[DVD_W-1:0];
			rem_q     <= '0;
			den_q     <= den;
			cnt_q     <= '0;
			idx_q     <= '0;
			bit_q     <= BIT_W'(IDX_W - 1);
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[DVD_W-2:0], q_bit};
			rem_q <= rem_next;
			cnt_q <= cnt_q + 1'b1;
		end else if (cmd.srch_step) begin
			if (try_ok) begin
				idx_q <= try_idx;
			end
			bit_q <= bit_q - 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			angle_q <= special_q ? spec_q : {quad_q, idx_q};
		end
	end

	assign stat.special   = s_zero || c_zero;
	assign stat.div_last  = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign stat.srch_last = (bit_q == '0);
	assign angle          = angle_q;

endmodule

[hw/rtl/baatan2_ctrl.sv]
// controller: sequencing of divide and search, handshakes of both channels
module baatan2_ctrl
	import baatan2_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = stat.special ? ST_HOLD : ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (stat.div_last) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (stat.srch_last) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd.start     = accept;
		cmd.div_step  = (state_q == ST_DIVIDE);
		cmd.srch_step = (state_q == ST_SEARCH);
		cmd.load_out  = (state_q == ST_HOLD) && out_free;
	end

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hw/rtl/binary_angle_atan2.sv]
// Four-quadrant arctangent returning an 8-bit binary angle (256 steps per
// turn, quadrant in the top two bits). One transaction is worked on at a
// time: an off-axis input passes from acceptance to the result register
// through the 30-step restoring divider (one quotient bit a cycle), then
// a 6-step binary search of the tangent table and the load of the result
// register; an input on an axis goes straight to the load of the result
// register. The next input is taken in the cycle after the result is
// loaded, and the load waits while a stalled result still holds the output.
// A new input is taken once the controller is back in idle, even while the
// previous result still waits at the output.
module binary_angle_atan2
	import baatan2_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [MAG_W-1:0]   sine_part,
	input  logic signed [MAG_W-1:0]   cosine_part,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic        [ANGLE_W-1:0] angle
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencing
	baatan2_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// arithmetic
	baatan2_dp u_dp (
		.clk         (clk),
		.sine_part   (sine_part),
		.cosine_part (cosine_part),
		.cmd         (cmd),
		.stat        (stat),
		.angle       (angle)
	);

endmodule

[hw/rtl/baatan2_chk.sv]
// port-level checks of the binary angle block and their binding
`include "binary_angle_atan2_macros.svh"

module baatan2_chk
	import baatan2_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [ANGLE_W-1:0] angle
);

	// a stalled result holds
	`BAA_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(angle))
	// an accepted transaction makes the block busy
	`BAA_ASSERT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall |=> in_stall)
	// a new result is only produced while a transaction is in work
	`BAA_ASSERT(a_result_from_work, clk, arst_n, $rose(out_valid) |-> $past(in_stall))
	// no result appears in the cycle right after an acceptance
	`BAA_ASSERT(a_no_instant_result, clk, arst_n, in_valid && !in_stall |=> !$rose(out_valid))

endmodule

bind binary_angle_atan2 baatan2_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.angle     (angle)
);
